@@ rtl/core/m4inv_pkg.sv @@
// package for the 4x4 fixed-point matrix inverse unit
// holds widths, cofactor term and minor pair tables; no dependencies
package m4inv_pkg;

  localparam int ElemWidth   = 32;
  localparam int FracBitsDef = 16;
  localparam int LimbWidth   = 32;
  localparam int NumLimbs    = 5;
  localparam int WideWidth   = LimbWidth * NumLimbs;
  localparam int ProdWidth   = 2 * (LimbWidth + 1);
  localparam int DivWidth    = WideWidth + 8;
  localparam int QuotWidth   = ElemWidth + 2;

  typedef struct packed {
    logic [1:0] col;
    logic [2:0] minor;
    logic       neg;
  } term_t;

  typedef struct packed {
    logic [1:0] ci;
    logic [1:0] cj;
  } pair_t;

  function automatic term_t term_f(input logic [1:0] k, input logic [1:0] t);
    term_t r;
    r = '0;
    case ({k, t})
      4'b0000: r = '{col: 2'd1, minor: 3'd4, neg: 1'b0};
      4'b0001: r = '{col: 2'd2, minor: 3'd3, neg: 1'b1};
      4'b0010: r = '{col: 2'd3, minor: 3'd2, neg: 1'b0};
      4'b0100: r = '{col: 2'd0, minor: 3'd4, neg: 1'b1};
      4'b0101: r = '{col: 2'd2, minor: 3'd5, neg: 1'b1};
      4'b0110: r = '{col: 2'd3, minor: 3'd1, neg: 1'b1};
      4'b1000: r = '{col: 2'd0, minor: 3'd3, neg: 1'b0};
      4'b1001: r = '{col: 2'd1, minor: 3'd5, neg: 1'b0};
      4'b1010: r = '{col: 2'd3, minor: 3'd0, neg: 1'b0};
      4'b1100: r = '{col: 2'd0, minor: 3'd2, neg: 1'b1};
      4'b1101: r = '{col: 2'd1, minor: 3'd1, neg: 1'b0};
      4'b1110: r = '{col: 2'd2, minor: 3'd0, neg: 1'b1};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic pair_t pair_f(input logic [2:0] k);
    pair_t r;
    r = '0;
    case (k)
      3'd0: r = '{ci: 2'd0, cj: 2'd1};
      3'd1: r = '{ci: 2'd0, cj: 2'd2};
      3'd2: r = '{ci: 2'd1, cj: 2'd2};
      3'd3: r = '{ci: 2'd1, cj: 2'd3};
      3'd4: r = '{ci: 2'd2, cj: 2'd3};
      3'd5: r = '{ci: 2'd3, cj: 2'd0};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/matrix4x4_inverse_unit.sv @@
// 4x4 matrix inverse by the adjugate, signed fixed point
// depends on m4inv_pkg
//
// usage:
//   input channel (in_valid_i/in_ready_o, element_i) takes the 16 elements
//   of a matrix in column-major order, one beat each. the first 15 beats
//   give no result.
//   after the 16th beat the unit forms 2x2 minors, cofactors and the
//   determinant with one 33x33 multiplier walking 32-bit limbs, then
//   divides each cofactor by the determinant with a restoring divider,
//   one quotient bit per cycle. in_ready_o is low from the last beat
//   until the unit returns to idle after giving its last result beat.
//   output channel (out_valid_o/out_ready_i) gives 16 beats, positions 0 to
//   15, last_o on position 15; a zero determinant gives one beat with
//   singular_o and last_o set instead.
//   the output register holds a beat while the receiver stalls; the divider
//   goes on to the next element but holds its result until that beat is taken.
//   reset empties the load count and drops any matrix in progress.
module matrix4x4_inverse_unit
  import m4inv_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [ElemWidth-1:0] element_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [ElemWidth-1:0] inverse_element_o,
  output logic [3:0]                  position_o,
  output logic                        singular_o,
  output logic                        saturated_o,
  output logic                        last_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_RD   = 10'b0000000010,
    S_LD   = 10'b0000000100,
    S_MUL  = 10'b0000001000,
    S_ACC  = 10'b0000010000,
    S_CHK  = 10'b0000100000,
    S_CRD  = 10'b0001000000,
    S_CLD  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_PUT  = 10'b1000000000
  } state_e;

  typedef enum logic [4:0] {
    P_MINA = 5'b00001,
    P_COFA = 5'b00010,
    P_MINB = 5'b00100,
    P_COFB = 5'b01000,
    P_DET  = 5'b10000
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic [3:0] cnt_q;
  logic [2:0] grp_q;
  logic [1:0] trm_q;
  logic [2:0] j_q;
  logic [3:0] k_q;
  logic [5:0] dcnt_q;
  logic       sing_q;

  logic [ElemWidth-1:0] store [16];
  logic [WideWidth-1:0] wmem [32];
  logic [ElemWidth-1:0] sd_a_q, sd_b_q;
  logic [WideWidth-1:0] wd_q;

  logic signed [ElemWidth-1:0] a_q;
  logic [WideWidth-1:0]        b_q;
  logic signed [ProdWidth-1:0] prod_q;
  logic signed [WideWidth-1:0] acc_q, acc_d, pe;
  logic signed [WideWidth-1:0] det_q;
  logic [WideWidth-1:0]        dabs_q;
  logic                        dneg_q, nneg_q;
  logic [DivWidth-1:0]         rem_q, dsh_q;
  logic [QuotWidth-1:0]        q_q;

  logic ov_q, os_q, osat_q, ol_q;
  logic [ElemWidth-1:0] oe_q;
  logic [3:0] op_q;

  // term decode
  logic [3:0] dec_a, dec_b;
  logic [4:0] dec_w, dec_dst;
  logic       dec_neg, dec_tl, dec_gl, is_min;
  logic [2:0] dec_nl;
  logic [1:0] ra, rb, row;
  pair_t      pr;
  term_t      tm;

  assign is_min = (phase_q == P_MINA) || (phase_q == P_MINB);
  assign ra     = (phase_q == P_MINA) ? 2'd2 : 2'd0;
  assign rb     = {ra[1], 1'b1};
  assign pr     = pair_f(grp_q);
  assign tm     = term_f(grp_q[1:0], trm_q);
  assign row    = (phase_q == P_COFA) ? (grp_q[2] ? 2'd0 : 2'd1)
                                      : (grp_q[2] ? 2'd2 : 2'd3);

  always_comb begin
    dec_a   = '0;
    dec_b   = '0;
    dec_w   = '0;
    dec_neg = 1'b0;
    dec_nl  = 3'd1;
    dec_tl  = 1'b0;
    dec_gl  = 1'b0;
    dec_dst = '0;
    case (phase_q)
      P_MINA, P_MINB: begin
        if (!trm_q[0]) begin
          dec_a = {pr.ci, ra};
          dec_b = {pr.cj, rb};
        end else begin
          dec_a   = {pr.ci, rb};
          dec_b   = {pr.cj, ra};
          dec_neg = 1'b1;
        end
        dec_nl  = 3'd1;
        dec_tl  = trm_q[0];
        dec_gl  = (grp_q == 3'd5);
        dec_dst = {2'b00, grp_q};
      end
      P_COFA, P_COFB: begin
        dec_a   = {tm.col, row};
        dec_w   = {2'b00, tm.minor};
        dec_neg = tm.neg ^ grp_q[2];
        dec_nl  = 3'd3;
        dec_tl  = (trm_q == 2'd2);
        dec_gl  = (grp_q == 3'd7);
        dec_dst = {1'b1, (phase_q == P_COFB), grp_q};
      end
      P_DET: begin
        dec_a  = {trm_q, 2'b00};
        dec_w  = {3'b100, trm_q};
        dec_nl = 3'd4;
        dec_tl = (trm_q == 2'd3);
        dec_gl = 1'b1;
      end
      default: ;
    endcase
  end

  // limb multiply and accumulate
  logic [LimbWidth-1:0]        lb;
  logic                        top_limb;
  logic signed [LimbWidth:0]   l33, a33;
  logic                        last_limb;

  assign lb        = b_q[{j_q, 5'd0} +: LimbWidth];
  assign last_limb = (j_q == dec_nl - 3'd1);
  assign top_limb  = last_limb;
  assign l33       = {top_limb ? lb[LimbWidth-1] : 1'b0, lb};
  assign a33       = {a_q[ElemWidth-1], a_q};
  assign pe        = $signed({{(WideWidth-ProdWidth){prod_q[ProdWidth-1]}}, prod_q})
                     <<< {j_q, 5'd0};
  assign acc_d     = dec_neg ? (acc_q - pe) : (acc_q + pe);

  logic wen;
  assign wen = (state_q == S_ACC) && last_limb && dec_tl && (phase_q != P_DET);

  // memories
  logic [4:0] wra;
  assign wra = (state_q == S_CRD) ? {1'b1, k_q} : dec_w;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      store[cnt_q] <= element_i;
    end
    sd_a_q <= store[dec_a];
    sd_b_q <= store[dec_b];
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      wmem[dec_dst] <= acc_d;
    end
    wd_q <= wmem[wra];
  end

  // division and result
  logic                    ge;
  logic [WideWidth-1:0]    cmag;
  logic                    cneg;
  logic [QuotWidth-2:0]    qv;
  logic                    big, sat;
  logic [ElemWidth-1:0]    val;
  localparam logic [QuotWidth-2:0] Half = (QuotWidth-1)'(1) << (ElemWidth - 1);

  assign ge   = (rem_q >= dsh_q);
  assign cneg = wd_q[WideWidth-1];
  assign cmag = cneg ? (~wd_q + 1'b1) : wd_q;
  assign qv   = q_q[QuotWidth-2:0];
  assign big  = q_q[QuotWidth-1];
  assign sat  = nneg_q ? (big || (qv > Half)) : (big || (qv >= Half));

  always_comb begin
    if (nneg_q) begin
      val = sat ? {1'b1, {(ElemWidth-1){1'b0}}} : (~qv[ElemWidth-1:0] + 1'b1);
    end else begin
      val = sat ? {1'b0, {(ElemWidth-1){1'b1}}} : qv[ElemWidth-1:0];
    end
  end

  logic put_ok;
  assign put_ok = !ov_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LD: begin
        a_q <= sd_a_q;
        b_q <= is_min ? {{(WideWidth-ElemWidth){sd_b_q[ElemWidth-1]}}, sd_b_q} : wd_q;
      end
      S_MUL: prod_q <= a33 * l33;
      S_CHK: begin
        dabs_q <= det_q[WideWidth-1] ? (~det_q + 1'b1) : det_q;
        dneg_q <= det_q[WideWidth-1];
      end
      S_CLD: begin
        rem_q  <= DivWidth'(cmag) << (2 * FRAC_BITS);
        dsh_q  <= DivWidth'(dabs_q) << (QuotWidth - 1);
        nneg_q <= cneg ^ dneg_q;
      end
      S_DIV: begin
        rem_q <= ge ? (rem_q - dsh_q) : rem_q;
        dsh_q <= dsh_q >> 1;
        q_q   <= {q_q[QuotWidth-2:0], ge};
      end
      default: ;
    endcase
    if (state_q == S_ACC && last_limb && dec_tl && dec_gl && phase_q == P_DET) begin
      det_q <= acc_d;
    end
    if (state_q == S_PUT && put_ok) begin
      oe_q   <= sing_q ? '0 : val;
      op_q   <= sing_q ? '0 : k_q;
      os_q   <= sing_q;
      osat_q <= sing_q ? 1'b0 : sat;
      ol_q   <= sing_q || (k_q == 4'd15);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= P_MINA;
      cnt_q   <= '0;
      grp_q   <= '0;
      trm_q   <= '0;
      j_q     <= '0;
      k_q     <= '0;
      dcnt_q  <= '0;
      sing_q  <= 1'b0;
      acc_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (state_q == S_PUT && put_ok) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cnt_q <= cnt_q + 4'd1;
            if (cnt_q == 4'd15) begin
              state_q <= S_RD;
              phase_q <= P_MINA;
              grp_q   <= '0;
              trm_q   <= '0;
              acc_q   <= '0;
            end
          end
        end
        S_RD: state_q <= S_LD;
        S_LD: begin
          j_q     <= '0;
          state_q <= S_MUL;
        end
        S_MUL: state_q <= S_ACC;
        S_ACC: begin
          if (!last_limb) begin
            acc_q   <= acc_d;
            j_q     <= j_q + 3'd1;
            state_q <= S_MUL;
          end else if (!dec_tl) begin
            acc_q   <= acc_d;
            trm_q   <= trm_q + 2'd1;
            state_q <= S_RD;
          end else begin
            acc_q <= '0;
            trm_q <= '0;
            if (!dec_gl) begin
              grp_q   <= grp_q + 3'd1;
              state_q <= S_RD;
            end else begin
              grp_q   <= '0;
              state_q <= S_RD;
              case (phase_q)
                P_MINA:  phase_q <= P_COFA;
                P_COFA:  phase_q <= P_MINB;
                P_MINB:  phase_q <= P_COFB;
                P_COFB:  phase_q <= P_DET;
                P_DET: begin
                  phase_q <= P_MINA;
                  state_q <= S_CHK;
                end
                default: phase_q <= P_MINA;
              endcase
            end
          end
        end
        S_CHK: begin
          k_q <= '0;
          if (det_q == '0) begin
            sing_q  <= 1'b1;
            state_q <= S_PUT;
          end else begin
            state_q <= S_CRD;
          end
        end
        S_CRD: state_q <= S_CLD;
        S_CLD: begin
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (dcnt_q == 6'(QuotWidth - 1)) begin
            state_q <= S_PUT;
          end else begin
            dcnt_q <= dcnt_q + 6'd1;
          end
        end
        S_PUT: begin
          if (put_ok) begin
            if (sing_q || k_q == 4'd15) begin
              sing_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              k_q     <= k_q + 4'd1;
              state_q <= S_CRD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = ov_q;
  assign inverse_element_o = oe_q;
  assign position_o        = op_q;
  assign singular_o        = os_q;
  assign saturated_o       = osat_q;
  assign last_o            = ol_q;

endmodule
